// ===== sv/i2c_mts_pkg.sv =====
// Package for the I2C master transaction sequencer: codes, types and defaults.
package i2c_mts_pkg;

   // Default depth of the transfer buffer
   localparam int BufDepthDef = 32;

   // Bus status code sits in the upper five bits
   localparam logic [7:0] StatusMask = 8'hF8;

   // Bus engine status codes
   localparam logic [7:0] StStart      = 8'h08;
   localparam logic [7:0] StRepStart   = 8'h10;
   localparam logic [7:0] StMtSlaAck   = 8'h18;
   localparam logic [7:0] StMtSlaNack  = 8'h20;
   localparam logic [7:0] StMtDataAck  = 8'h28;
   localparam logic [7:0] StMtDataNack = 8'h30;
   localparam logic [7:0] StArbLost    = 8'h38;
   localparam logic [7:0] StMrSlaAck   = 8'h40;
   localparam logic [7:0] StMrDataAck  = 8'h50;
   localparam logic [7:0] StMrDataNack = 8'h58;

   // Transaction commands
   typedef enum logic [1:0] {
      CmdBegin = 2'd0,
      CmdEvent = 2'd1,
      CmdWrite = 2'd2,
      CmdRead  = 2'd3
   } cmd_type;

   // Bus actions
   typedef enum logic [2:0] {
      ActNone     = 3'd0,
      ActStart    = 3'd1,
      ActStop     = 3'd2,
      ActCont     = 3'd3,
      ActContAck  = 3'd4,
      ActResetAck = 3'd5
   } action_type;

   // Begin command result codes
   typedef enum logic [1:0] {
      RcOk     = 2'd0,
      RcBusy   = 2'd1,
      RcLength = 2'd2
   } result_type;

   // Result waiting for buffer read data
   typedef struct packed {
      action_type action;
      logic       tx_valid;
      logic [7:0] tx_pre;
      logic       tx_mem;
      logic       rd_mem;
      logic       busy;
      logic [7:0] status;
      logic [7:0] error;
      logic [5:0] count;
      result_type result_code;
   } pend_type;

   // Complete result transaction
   typedef struct packed {
      action_type action;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       busy;
      logic [7:0] status;
      logic [7:0] error;
      logic [5:0] count;
      logic [7:0] read_data;
      result_type result_code;
   } rsp_type;

endpackage

// ===== sv/i2c_master_transaction_sequencer.sv =====
// I2C master transaction sequencer: command decode, transfer buffer and result queue.
//
// Request channel (req_*): one transaction per command. Begin, if not busy and the
// length fits the buffer, latches the slave address, direction and length and asks
// for a start; a bus status event is decoded into the next bus action and any byte to
// load into the bus data register; buffer write and read commands access the buffer directly.
// Response channel (rsp_*): exactly one result transaction per request, in order.
// The accepting edge updates the state and reads the buffer into the read stage; from
// there the result passes into the result queue, which raises rsp_valid, and it is
// taken when rsp_valid is high and rsp_stall is low.
// Throughput: one transaction per cycle while the receiver keeps rsp_stall low.
// A two-entry result queue behind the buffer read register lets a request be taken
// while a result waits; req_stall rises once the queue and the read stage would
// fill, and falls as soon as the receiver takes a result.
// Reset clears busy, position, size, address byte, status and error, and empties
// the pipeline. Buffer contents are not cleared; read an entry only once written.
module i2c_master_transaction_sequencer #(
   parameter int BUF_DEPTH = i2c_mts_pkg::BufDepthDef
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [6:0] req_slave_addr,
   input  logic       req_direction,
   input  logic [7:0] req_length,
   input  logic [7:0] req_bus_status,
   input  logic [7:0] req_bus_byte,
   input  logic [4:0] req_buf_index,
   input  logic [7:0] req_buf_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_action,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_busy_res,
   output logic [7:0] rsp_status_seen,
   output logic [7:0] rsp_error_seen,
   output logic [5:0] rsp_byte_count,
   output logic [7:0] rsp_read_data,
   output logic [1:0] rsp_result_code
);
   import i2c_mts_pkg::*;

   localparam int PosW  = $clog2(BUF_DEPTH + 1);
   localparam int AddrW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam logic [7:0] DepthB = 8'(BUF_DEPTH);

   // Sequencer state
   logic [PosW-1:0]  position_ff, position_in;
   logic [PosW-1:0]  size_ff, size_in;
   logic [7:0]       addr_ff, addr_in;
   logic             busy_ff, busy_in;
   logic [7:0]       status_ff, status_in;
   logic [7:0]       error_ff, error_in;

   // Transfer buffer
   logic [7:0]       mem [BUF_DEPTH];
   logic [7:0]       mem_rd_ff;
   logic             mem_we;
   logic [AddrW-1:0] mem_wa, mem_ra;
   logic [7:0]       mem_wd;

   // Read stage and result queue
   logic             p_vld_ff;
   pend_type         p_ff, p_in;
   rsp_type          p_res;
   rsp_type          fifo_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       cnt_ff, cnt_in;

   logic             acc, pop;
   logic [2:0]       occ;
   logic [7:0]       code;
   cmd_type          cmd;
   action_type       act;
   logic [PosW-1:0]  pos_inc;
   logic             more;
   logic             idx_ok;
   logic [AddrW-1:0] pos_idx, buf_idx;

   // Handshake
   assign pop       = rsp_valid & ~rsp_stall;
   assign occ       = {1'b0, cnt_ff} + {2'b0, p_vld_ff} - {2'b0, pop};
   assign req_stall = (occ >= 3'd2);
   assign acc       = req_valid & ~req_stall;

   // Field decode
   assign cmd     = cmd_type'(req_cmd);
   assign code    = req_bus_status & StatusMask;
   assign pos_inc = position_ff + PosW'(1);
   assign more    = (position_ff < size_ff);
   assign idx_ok  = ({3'b0, req_buf_index} < DepthB);
   assign pos_idx = position_ff[AddrW-1:0];
   assign buf_idx = AddrW'(req_buf_index);

   // Command and status decode, next state
   always_comb begin
      act         = ActNone;
      p_in        = '0;
      position_in = position_ff;
      size_in     = size_ff;
      addr_in     = addr_ff;
      status_in   = status_ff;
      error_in    = error_ff;
      mem_we      = 1'b0;
      mem_wa      = pos_idx;
      mem_wd      = req_bus_byte;
      mem_ra      = pos_idx;
      p_in.result_code = RcOk;
      unique case (cmd)
         CmdBegin: begin
            if (busy_ff) begin
               p_in.result_code = RcBusy;
            end else if (req_length > DepthB) begin
               p_in.result_code = RcLength;
            end else begin
               size_in = PosW'(req_length);
               if (!req_direction) begin
                  position_in = '0;
               end
               addr_in = {req_slave_addr, req_direction};
               act     = ActStart;
            end
         end
         CmdEvent: begin
            status_in = code;
            error_in  = '0;
            unique case (code) inside
               StStart, StRepStart: begin
                  p_in.tx_valid = 1'b1;
                  p_in.tx_pre   = addr_ff;
                  position_in   = '0;
                  act           = ActCont;
               end
               StMtSlaAck, StMtDataAck: begin
                  if (more) begin
                     p_in.tx_valid = 1'b1;
                     p_in.tx_mem   = 1'b1;
                     position_in   = pos_inc;
                     act           = ActCont;
                  end else begin
                     act = ActStop;
                  end
               end
               StMrSlaAck: begin
                  act = ActContAck;
               end
               StMrDataAck, StMrDataNack: begin
                  if (more) begin
                     mem_we      = 1'b1;
                     position_in = pos_inc;
                     // bytes left after this one decide ack or nack
                     if (size_ff == pos_inc) begin
                        act = ActStop;
                     end else if ({1'b0, size_ff} == {1'b0, pos_inc} + (PosW+1)'(1)) begin
                        act = ActCont;
                     end else begin
                        act = ActContAck;
                     end
                  end else begin
                     act = ActStop;
                  end
               end
               StMtSlaNack, StArbLost: begin
                  error_in = code;
                  act      = ActStart;
               end
               StMtDataNack: begin
                  error_in = code;
                  act      = ActStop;
               end
               default: begin
                  error_in = code;
                  act      = ActResetAck;
               end
            endcase
         end
         CmdWrite: begin
            if (idx_ok) begin
               mem_we = 1'b1;
               mem_wa = buf_idx;
               mem_wd = req_buf_data;
            end
         end
         CmdRead: begin
            if (idx_ok) begin
               p_in.rd_mem = 1'b1;
               mem_ra      = buf_idx;
            end
         end
         default: begin
            act = ActNone;
         end
      endcase

      // Busy follows the action issued
      if (act == ActStop) begin
         busy_in = 1'b0;
      end else if (act != ActNone) begin
         busy_in = 1'b1;
      end else begin
         busy_in = busy_ff;
      end

      p_in.action = act;
      p_in.busy   = busy_in;
      p_in.status = status_in;
      p_in.error  = error_in;
      p_in.count  = 6'(position_in);
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         size_ff     <= '0;
         addr_ff     <= '0;
         busy_ff     <= 1'b0;
         status_ff   <= '0;
         error_ff    <= '0;
      end else if (acc) begin
         position_ff <= position_in;
         size_ff     <= size_in;
         addr_ff     <= addr_in;
         busy_ff     <= busy_in;
         status_ff   <= status_in;
         error_ff    <= error_in;
      end
   end

   // Buffer write and registered read
   always_ff @(posedge clock) begin
      if (acc && mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (acc) begin
         mem_rd_ff <= mem[mem_ra];
      end
   end

   // Read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= acc;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         p_ff <= p_in;
      end
   end

   // Merge buffer read data into the result
   always_comb begin
      p_res.action      = p_ff.action;
      p_res.tx_valid    = p_ff.tx_valid;
      p_res.tx_byte     = p_ff.tx_mem ? mem_rd_ff : p_ff.tx_pre;
      p_res.busy        = p_ff.busy;
      p_res.status      = p_ff.status;
      p_res.error       = p_ff.error;
      p_res.count       = p_ff.count;
      p_res.read_data   = p_ff.rd_mem ? mem_rd_ff : 8'h00;
      p_res.result_code = p_ff.result_code;
   end

   // Result queue
   always_comb begin
      cnt_in = cnt_ff;
      if (p_vld_ff && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!p_vld_ff && pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (p_vld_ff) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_vld_ff) begin
         fifo_ff[wr_ptr_ff] <= p_res;
      end
   end

   // Response outputs
   assign rsp_valid       = (cnt_ff != 2'd0);
   assign rsp_action      = fifo_ff[rd_ptr_ff].action;
   assign rsp_tx_valid    = fifo_ff[rd_ptr_ff].tx_valid;
   assign rsp_tx_byte     = fifo_ff[rd_ptr_ff].tx_byte;
   assign rsp_busy_res    = fifo_ff[rd_ptr_ff].busy;
   assign rsp_status_seen = fifo_ff[rd_ptr_ff].status;
   assign rsp_error_seen  = fifo_ff[rd_ptr_ff].error;
   assign rsp_byte_count  = fifo_ff[rd_ptr_ff].count;
   assign rsp_read_data   = fifo_ff[rd_ptr_ff].read_data;
   assign rsp_result_code = fifo_ff[rd_ptr_ff].result_code;

   // Checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue count out of range");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      p_vld_ff |-> !(cnt_ff == 2'd2 && !pop))
      else $error("read stage result has no queue room");

   a_accept_flows: assert property (@(posedge clock) disable iff (reset)
      acc |=> p_vld_ff)
      else $error("accepted transaction lost before read stage");

   a_begin_busy: assert property (@(posedge clock) disable iff (reset)
      (acc && cmd == CmdBegin && busy_ff) |=> (p_ff.result_code == RcBusy && busy_ff))
      else $error("begin while busy not refused");

   a_stop_idle: assert property (@(posedge clock) disable iff (reset)
      (acc && act == ActStop) |=> !busy_ff)
      else $error("busy still set after stop");

endmodule
